/* hw/rtl/uia_pkg.sv */
// Shared types, codes and constants of the ultrasonic intrusion alarm.
package uia_pkg;

	localparam int unsigned ENTRY_MAX = 99;
	localparam int unsigned COUNT_W = $clog2(ENTRY_MAX + 1);
	localparam int unsigned CODE_LEN = 4;
	localparam int unsigned CODE_IDX_W = $clog2(CODE_LEN);
	localparam int unsigned TIME_W = 16;
	localparam int unsigned DIST_W = 18;
	localparam int unsigned DIST_MUL = 2125;
	localparam int unsigned DIST_SHIFT = 10;
	localparam int unsigned PROD_W = DIST_W + DIST_SHIFT;
	localparam int unsigned OPQ_DEPTH = 4;
	localparam int unsigned RQ_DEPTH = 2;

	localparam logic [1:0] CMD_ECHO = 2'd0;
	localparam logic [1:0] CMD_CHAR = 2'd1;
	localparam logic [1:0] CMD_BUTTON = 2'd2;

	localparam logic [7:0] CHAR_CR = 8'd13;
	localparam logic [7:0] CHAR_LF = 8'd10;

	localparam logic [1:0] RES_NONE = 2'd0;
	localparam logic [1:0] RES_ARMED = 2'd1;
	localparam logic [1:0] RES_DISARMED = 2'd2;
	localparam logic [1:0] RES_WRONG = 2'd3;

	localparam logic [1:0] REG_ALARM_BELOW = 2'd0;
	localparam logic [1:0] REG_CLEAR_ABOVE = 2'd1;
	localparam logic [1:0] REG_ACCESS_CODE = 2'd2;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_MEASURE,
		OP_CODE_OK,
		OP_CODE_BAD,
		OP_BUTTON
	} op_kind_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] capture_time;
		logic [7:0]  rx_char;
	} in_item_t;

	typedef struct packed {
		logic        armed;
		logic        alarm_on;
		logic        alarm_raised;
		logic        measure_done;
		logic [17:0] distance_cm;
		logic [1:0]  code_result;
	} out_item_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [DIST_W-1:0] distance;
	} op_t;

endpackage

/* hw/rtl/uia_front.sv */
// Front end: tracks echo edges and code entry, and turns each request into an operation.
module uia_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  uia_pkg::in_item_t item,
	input  logic [31:0]       access_code,
	output uia_pkg::op_t      op
);
	import uia_pkg::*;

	logic                   awaiting_q;
	logic [TIME_W-1:0]      start_q;
	logic [COUNT_W-1:0]     count_q;
	logic                   mismatch_q;
	logic                   awaiting_d;
	logic [TIME_W-1:0]      start_d;
	logic [COUNT_W-1:0]     count_d;
	logic                   mismatch_d;
	logic [TIME_W-1:0]      dt;
	logic [PROD_W-1:0]      prod;
	logic [CODE_IDX_W-1:0]  idx;
	logic [7:0]             want;

	assign dt = item.capture_time - start_q;
	assign prod = PROD_W'(dt) * PROD_W'(DIST_MUL);
	assign idx = count_q[CODE_IDX_W-1:0];
	assign want = access_code[8 * (CODE_LEN - 1 - 32'(idx)) +: 8];

	always_comb begin
		awaiting_d = awaiting_q;
		start_d = start_q;
		count_d = count_q;
		mismatch_d = mismatch_q;
		op.kind = OP_NONE;
		op.distance = prod[PROD_W-1:DIST_SHIFT];
		case (item.command)
			CMD_ECHO: begin
				if (!awaiting_q) begin
					start_d = item.capture_time;
					awaiting_d = 1'b1;
				end else begin
					awaiting_d = 1'b0;
					op.kind = OP_MEASURE;
				end
			end
			CMD_CHAR: begin
				if (item.rx_char == CHAR_CR || item.rx_char == CHAR_LF) begin
					if (count_q != '0) begin
						if (count_q == COUNT_W'(CODE_LEN) && !mismatch_q) begin
							op.kind = OP_CODE_OK;
						end else begin
							op.kind = OP_CODE_BAD;
						end
						count_d = '0;
						mismatch_d = 1'b0;
					end
				end else if (count_q < COUNT_W'(ENTRY_MAX)) begin
					if (count_q >= COUNT_W'(CODE_LEN) || want != item.rx_char) begin
						mismatch_d = 1'b1;
					end
					count_d = count_q + 1'b1;
				end
			end
			CMD_BUTTON: begin
				op.kind = OP_BUTTON;
			end
			default: begin
				op.kind = OP_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			start_q <= '0;
			count_q <= '0;
			mismatch_q <= 1'b0;
		end else if (accept) begin
			awaiting_q <= awaiting_d;
			start_q <= start_d;
			count_q <= count_d;
			mismatch_q <= mismatch_d;
		end
	end

endmodule

/* hw/rtl/uia_opq.sv */
// Short operation queue between the front end and the back end.
module uia_opq (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  uia_pkg::op_t wr_op,
	output logic         full,
	input  logic         rd_en,
	output uia_pkg::op_t rd_op,
	output logic         empty
);
	import uia_pkg::*;

	localparam int unsigned PTR_W = $clog2(OPQ_DEPTH);
	localparam int unsigned CNT_W = $clog2(OPQ_DEPTH + 1);

	op_t              mem_q [OPQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full = count_q == CNT_W'(OPQ_DEPTH);
	assign empty = count_q == '0;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/uia_back.sv */
// Back end: applies operations to the armed and alarm state and queues the results.
module uia_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	input  uia_pkg::op_t       op,
	output logic               op_pop,
	input  logic [7:0]         alarm_below,
	input  logic [7:0]         clear_above,
	output logic               empty,
	input  logic               pop,
	output uia_pkg::out_item_t result
);
	import uia_pkg::*;

	localparam int unsigned PTR_W = $clog2(RQ_DEPTH);
	localparam int unsigned CNT_W = $clog2(RQ_DEPTH + 1);

	logic              armed_q;
	logic              alarm_q;
	logic [DIST_W-1:0] last_q;
	logic              armed_d;
	logic              alarm_d;
	logic [DIST_W-1:0] last_d;
	out_item_t         res_d;
	out_item_t         rq_q [RQ_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              rq_full;
	logic              do_rd;

	assign rq_full = count_q == CNT_W'(RQ_DEPTH);
	assign empty = count_q == '0;
	assign op_pop = op_valid && !rq_full;
	assign do_rd = pop && !empty;
	assign result = rq_q[rd_ptr_q];

	always_comb begin
		armed_d = armed_q;
		alarm_d = alarm_q;
		last_d = last_q;
		res_d.alarm_raised = 1'b0;
		res_d.measure_done = 1'b0;
		res_d.code_result = RES_NONE;
		case (op.kind)
			OP_MEASURE: begin
				last_d = op.distance;
				res_d.measure_done = 1'b1;
				if (armed_q && op.distance < DIST_W'(alarm_below)) begin
					if (!alarm_q) begin
						alarm_d = 1'b1;
						res_d.alarm_raised = 1'b1;
					end
				end else if (armed_q && op.distance > DIST_W'(clear_above)) begin
					alarm_d = 1'b0;
				end
			end
			OP_CODE_OK: begin
				if (armed_q) begin
					armed_d = 1'b0;
					alarm_d = 1'b0;
					res_d.code_result = RES_DISARMED;
				end else begin
					armed_d = 1'b1;
					res_d.code_result = RES_ARMED;
				end
			end
			OP_CODE_BAD: begin
				res_d.code_result = RES_WRONG;
			end
			OP_BUTTON: begin
				armed_d = 1'b0;
				alarm_d = 1'b0;
			end
			default: begin
				armed_d = armed_q;
			end
		endcase
		res_d.armed = armed_d;
		res_d.alarm_on = alarm_d;
		res_d.distance_cm = last_d;
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			rq_q[wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			alarm_q <= 1'b0;
			last_q <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (op_pop) begin
				armed_q <= armed_d;
				alarm_q <= alarm_d;
				last_q <= last_d;
				wr_ptr_q <= (wr_ptr_q == PTR_W'(RQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(RQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({op_pop, do_rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hw/rtl/ultrasonic_intrusion_alarm.sv */
// Top level of the ultrasonic intrusion alarm: configuration registers and the front and back ends.
// Each request (echo edge, serial character or button press) yields exactly one result. A
// request can be pushed every cycle while full is low. The front end classifies it in the
// cycle it is accepted, including the distance multiply, and writes an operation into a
// four-entry queue; the back end takes one operation a cycle from it while the two-entry
// result queue has room and places its result there, from which the result ports read.
// Full rises only when the operation queue has filled because results are not being popped.
// Configuration writes are always taken and should be made while idle.
module ultrasonic_intrusion_alarm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  uia_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output uia_pkg::out_item_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import uia_pkg::*;

	logic [7:0]  alarm_below_q;
	logic [7:0]  clear_above_q;
	logic [31:0] access_code_q;
	logic        accept;
	op_t         front_op;
	op_t         q_op;
	logic        q_empty;
	logic        q_pop;

	assign cfg_ready = 1'b1;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_below_q <= 8'd50;
			clear_above_q <= 8'd60;
			access_code_q <= 32'h3132_3334;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ALARM_BELOW: alarm_below_q <= cfg_data[7:0];
				REG_CLEAR_ABOVE: clear_above_q <= cfg_data[7:0];
				REG_ACCESS_CODE: access_code_q <= cfg_data;
				default: alarm_below_q <= alarm_below_q;
			endcase
		end
	end

	uia_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.item        (item),
		.access_code (access_code_q),
		.op          (front_op)
	);

	uia_opq u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wr_op  (front_op),
		.full   (full),
		.rd_en  (q_pop),
		.rd_op  (q_op),
		.empty  (q_empty)
	);

	uia_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (!q_empty),
		.op          (q_op),
		.op_pop      (q_pop),
		.alarm_below (alarm_below_q),
		.clear_above (clear_above_q),
		.empty       (empty),
		.pop         (pop),
		.result      (result)
	);

endmodule

/* hw/rtl/uia_checker.sv */
// Port-level checks of the ultrasonic intrusion alarm and their binding to the top level.
module uia_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input uia_pkg::out_item_t result
);
	import uia_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed before it was popped");

	a_alarm_needs_arm: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.armed || !result.alarm_on)
		else $error("alarm active while disarmed");

	a_raise: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.alarm_raised |-> result.alarm_on && result.measure_done)
		else $error("alarm raised without a measurement leaving it on");

	a_disarm: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.code_result == RES_DISARMED |-> !result.armed && !result.alarm_on)
		else $error("disarm result leaves the system armed or alarming");

endmodule

bind ultrasonic_intrusion_alarm uia_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
